FILE: hw/rtl/bte_pkg.sv
// Shared types and constants for the biphase tape waveform encoder.
// No dependencies; imported by every module of the block.
package bte_pkg;

	// Operation codes of an input beat
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_LOAD  = 2'd2,
		OP_NOP   = 2'd3
	} bte_op_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_HALF_BIT = 2'd0;
	localparam logic [1:0] CFG_LEADER   = 2'd1;
	localparam logic [1:0] CFG_SYNC     = 2'd2;

	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  HALF_BIT_RST = 8'd20;
	localparam logic [15:0] LEADER_RST   = 16'd256;
	localparam logic [7:0]  SYNC_RST     = 8'hE6;

	// Output levels
	localparam logic signed [15:0] LEVEL_HIGH = 16'sh7FFF;
	localparam logic signed [15:0] LEVEL_LOW  = 16'sh8000;

	// Bits per byte on tape
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Frame phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_LEADER = 4'b0010,
		PH_SYNC   = 4'b0100,
		PH_DATA   = 4'b1000
	} bte_phase_t;

	// Input beat
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       last_byte;
	} bte_in_t;

	// Output beat
	typedef struct packed {
		logic signed [15:0] sample;
		logic               sample_valid;
		logic               byte_request;
		logic               done_res;
	} bte_out_t;

	// Classified command between front and back
	typedef struct packed {
		logic       is_start;
		logic       is_tick;
		logic       is_load;
		logic [7:0] data_byte;
		logic       last_byte;
	} bte_cmd_t;

	// Configuration register set
	typedef struct packed {
		logic [7:0]  half_bit_samples;
		logic [15:0] leader_bytes;
		logic [7:0]  sync_byte;
	} bte_cfg_t;

endpackage

FILE: hw/rtl/bte_front.sv
// Front end: accepts input beats, decodes the operation and queues commands.
// Depends on bte_pkg.
module bte_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bte_pkg::bte_in_t  in_data,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output bte_pkg::bte_cmd_t cmd
);
	import bte_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	bte_cmd_t         queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	bte_cmd_t         dec;
	logic             push;

	// Classify the incoming operation
	always_comb begin
		dec           = '0;
		dec.data_byte = in_data.data_byte;
		dec.last_byte = in_data.last_byte;
		case (bte_op_t'(in_data.operation))
			OP_START: dec.is_start = 1'b1;
			OP_TICK:  dec.is_tick  = 1'b1;
			OP_LOAD:  dec.is_load  = 1'b1;
			default:  ;
		endcase
	end

	assign in_stall  = (count_q == CNT_FULL);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/bte_back.sv
// Back end: frame sequencer, biphase bit timing and the output register.
// Depends on bte_pkg.
module bte_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bte_pkg::bte_cfg_t cfg,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  bte_pkg::bte_cmd_t cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output bte_pkg::bte_out_t out_data
);
	import bte_pkg::*;

	bte_phase_t  phase_q, n_phase;
	logic [15:0] leader_left_q, n_leader_left;
	logic [7:0]  shift_reg_q, n_shift_reg;
	logic [3:0]  bits_left_q, n_bits_left;
	logic        second_half_q, n_second_half;
	logic [7:0]  ticks_left_q, n_ticks_left;
	logic [7:0]  hold_byte_q, n_hold_byte;
	logic        hold_valid_q, n_hold_valid;
	logic        hold_last_q, n_hold_last;
	logic        current_last_q, n_current_last;
	logic [7:0]  half_len;
	bte_out_t    res;
	logic        out_valid_q;
	bte_out_t    out_data_q;

	assign half_len = (cfg.half_bit_samples == '0) ? 8'd1 : cfg.half_bit_samples;

	// Take a command whenever the output register is free or draining
	assign cmd_pop = cmd_valid && (!out_valid_q || !out_stall);

	// Next state and result for the command at the queue head
	always_comb begin
		n_phase        = phase_q;
		n_leader_left  = leader_left_q;
		n_shift_reg    = shift_reg_q;
		n_bits_left    = bits_left_q;
		n_second_half  = second_half_q;
		n_ticks_left   = ticks_left_q;
		n_hold_byte    = hold_byte_q;
		n_hold_valid   = hold_valid_q;
		n_hold_last    = hold_last_q;
		n_current_last = current_last_q;
		res            = '0;

		if (cmd.is_start) begin
			n_hold_valid   = 1'b0;
			n_hold_last    = 1'b0;
			n_current_last = 1'b0;
			n_leader_left  = cfg.leader_bytes;
			n_bits_left    = BYTE_BITS;
			n_second_half  = 1'b0;
			n_ticks_left   = half_len;
			if (cfg.leader_bytes != '0) begin
				n_phase     = PH_LEADER;
				n_shift_reg = '0;
			end else begin
				n_phase     = PH_SYNC;
				n_shift_reg = cfg.sync_byte;
			end
		end else if (cmd.is_load) begin
			n_hold_byte  = cmd.data_byte;
			n_hold_last  = cmd.last_byte;
			n_hold_valid = 1'b1;
		end else if (cmd.is_tick && phase_q != PH_IDLE) begin
			// pull the held byte in when the data phase runs dry
			if (phase_q == PH_DATA && bits_left_q == '0 && hold_valid_q) begin
				n_shift_reg    = hold_byte_q;
				n_bits_left    = BYTE_BITS;
				n_second_half  = 1'b0;
				n_ticks_left   = half_len;
				n_current_last = hold_last_q;
				n_hold_valid   = 1'b0;
			end
			if (n_bits_left != '0) begin
				res.sample       = (n_shift_reg[7] ^ n_second_half) ? LEVEL_HIGH : LEVEL_LOW;
				res.sample_valid = 1'b1;
				if (n_ticks_left <= 8'd1) begin
					n_ticks_left = half_len;
					if (!n_second_half) begin
						n_second_half = 1'b1;
					end else begin
						n_second_half = 1'b0;
						n_shift_reg   = {n_shift_reg[6:0], 1'b0};
						n_bits_left   = n_bits_left - 1'b1;
						// end of byte: advance the frame
						if (n_bits_left == '0) begin
							case (phase_q)
								PH_LEADER: begin
									n_leader_left = leader_left_q - 1'b1;
									n_bits_left   = BYTE_BITS;
									if (n_leader_left != '0) begin
										n_shift_reg = '0;
									end else begin
										n_phase     = PH_SYNC;
										n_shift_reg = cfg.sync_byte;
									end
								end
								PH_SYNC: n_phase = PH_DATA;
								PH_DATA: begin
									if (n_current_last) begin
										n_phase        = PH_IDLE;
										n_current_last = 1'b0;
										res.done_res   = 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
				end else begin
					n_ticks_left = n_ticks_left - 1'b1;
				end
			end
		end

		res.byte_request = (n_phase == PH_DATA) && !n_hold_valid && !n_current_last;
	end

	// Encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			leader_left_q  <= '0;
			shift_reg_q    <= '0;
			bits_left_q    <= '0;
			second_half_q  <= 1'b0;
			ticks_left_q   <= '0;
			hold_byte_q    <= '0;
			hold_valid_q   <= 1'b0;
			hold_last_q    <= 1'b0;
			current_last_q <= 1'b0;
		end else if (cmd_pop) begin
			phase_q        <= n_phase;
			leader_left_q  <= n_leader_left;
			shift_reg_q    <= n_shift_reg;
			bits_left_q    <= n_bits_left;
			second_half_q  <= n_second_half;
			ticks_left_q   <= n_ticks_left;
			hold_byte_q    <= n_hold_byte;
			hold_valid_q   <= n_hold_valid;
			hold_last_q    <= n_hold_last;
			current_last_q <= n_current_last;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hw/rtl/biphase_tape_waveform_encoder.sv
// An accepted input beat passes the command queue, then the output register.
// Throughput: one beat per cycle unless stalled, set by the bte_back encoder update.
// A QUEUE_DEPTH-entry command queue lets input and output stall independently.
// Reset (arst_n low, asynchronous): frame idle, queue empty, output empty,
// registers back to 20 ticks per half bit, 256 leader bytes, sync byte 0xE6.
module biphase_tape_waveform_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bte_pkg::bte_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bte_pkg::bte_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [bte_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bte_pkg::*;

	bte_cfg_t cfg_q;
	logic     cmd_valid;
	logic     cmd_pop;
	bte_cmd_t cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_samples <= HALF_BIT_RST;
			cfg_q.leader_bytes     <= LEADER_RST;
			cfg_q.sync_byte        <= SYNC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_BIT: cfg_q.half_bit_samples <= cfg_data[7:0];
				CFG_LEADER:   cfg_q.leader_bytes     <= cfg_data;
				CFG_SYNC:     cfg_q.sync_byte        <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	bte_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	bte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: hw/rtl/bte_checker.sv
// Port-level checks for the biphase tape waveform encoder, bound to the top level.
// Depends on bte_pkg and biphase_tape_waveform_encoder.
module bte_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input bte_pkg::bte_out_t out_data
);
	import bte_pkg::*;

	// A stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// No sample means a zero sample word
	a_no_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sample_valid |-> out_data.sample == '0)
		else $error("sample nonzero without sample_valid");

	// Samples are full scale only
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sample_valid |->
			out_data.sample == LEVEL_HIGH || out_data.sample == LEVEL_LOW)
		else $error("sample not at a full-scale level");

	// Frame end comes with a sample and leaves nothing requested
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |->
			out_data.sample_valid && !out_data.byte_request)
		else $error("done without sample or with byte request");

endmodule

bind biphase_tape_waveform_encoder bte_checker u_bte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
